[rtl/core/uart_command_frame_parser_macros.svh]
// assertion macros shared by the uart command frame parser
`ifndef UART_COMMAND_FRAME_PARSER_MACROS_SVH
`define UART_COMMAND_FRAME_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication under reset
`define UCFP_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("assertion failed");
// next-cycle implication under reset
`define UCFP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define UCFP_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define UCFP_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

[rtl/core/ucfp_pkg.sv]
// shared types, constants and helper functions of the uart command frame parser
package ucfp_pkg;

	// command codes of a result item
	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_FRAME   = 3'd1,
		CMD_BITS    = 3'd2,
		CMD_TEXT    = 3'd3,
		CMD_ENABLE  = 3'd4,
		CMD_DISABLE = 3'd5
	} cmd_t;

	// input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       burst_end;
	} rx_item_t;

	// result item
	typedef struct packed {
		cmd_t       command;
		logic [4:0] pin_mask;
		logic [4:0] pin_levels;
		logic       bits_mode;
	} res_item_t;

	// classified burst handed from front to back
	typedef struct packed {
		cmd_t       kind;
		logic [3:0] nibble;
		logic [2:0] pin;
	} burst_rec_t;

	localparam logic [7:0] FRAME_HEAD = 8'hDE;
	localparam logic [7:0] FRAME_TAIL = 8'hA1;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] DIGIT_LO   = 8'h30;
	localparam logic [7:0] DIGIT_HI   = 8'h34;
	localparam logic [3:0] FRAME_PINS = 4'hF;

	localparam int LEN_MODE = 13;
	localparam int LEN_EN   = 14;
	localparam int LEN_DIS  = 15;

	// command texts, left justified in 16 characters
	localparam logic [127:0] LIT_BITS = {"uart out bits", 24'h0};
	localparam logic [127:0] LIT_TEXT = {"uart out text", 24'h0};
	localparam logic [127:0] LIT_EN   = {"enable output ", 16'h0};
	localparam logic [127:0] LIT_DIS  = {"disable output ", 8'h0};

	// character at a position of a left-justified text
	function automatic logic [7:0] lit_char(input logic [127:0] s, input logic [3:0] pos);
		logic [3:0] rev;
		rev = 4'd15 - pos;
		return s[{rev, 3'b000} +: 8];
	endfunction

	// crc-8 of one byte, msb first, zero initial value
	function automatic logic [7:0] crc8(input logic [7:0] b);
		logic [7:0] c;
		c = b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[rtl/core/ucfp_stream_if.sv]
// valid/ready channel carrying one item per handshake
interface ucfp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/ucfp_front.sv]
// front end: takes bytes, matches commands per byte, emits one record per burst
module ucfp_front #(
	parameter int BURST_BYTES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	ucfp_stream_if.sink        rx,
	output logic               push_valid,
	input  logic               push_ready,
	output ucfp_pkg::burst_rec_t push_rec
);

	localparam int CW = $clog2(BURST_BYTES + 1);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_after;
	logic [3:0]    pos;
	logic [7:0]    byte_v;
	logic          first;
	logic          stored;
	logic          accept;

	logic       head_ok_q, crc_ok_q;
	logic [7:0] payload_q;
	logic       bits_ok_q, text_ok_q, en_ok_q, dis_ok_q;
	logic       bits_n, text_n, en_n, dis_n;
	logic       dig_en_ok_q, dig_dis_ok_q, dig_en_ok_n, dig_dis_ok_n;
	logic [2:0] dig_en_q, dig_dis_q, dig_en_n, dig_dis_n;
	logic       is_digit;
	logic       frame_hit;

	// one prefix step: restart on the first byte, check only inside the text
	function automatic logic step(input logic flag, input logic first_b,
	                              input logic in_text, input logic hit);
		return (first_b | flag) & (~in_text | hit);
	endfunction

	// position and byte bookkeeping
	always_comb begin
		byte_v    = rx.payload.data_byte;
		first     = (cnt_q == '0);
		stored    = (cnt_q < CW'(BURST_BYTES));
		pos       = cnt_q[3:0];
		cnt_after = stored ? cnt_q + CW'(1) : cnt_q;
		is_digit  = (byte_v >= ucfp_pkg::DIGIT_LO) && (byte_v <= ucfp_pkg::DIGIT_HI);
		accept    = rx.valid && rx.ready;
	end

	// prefix flags and digits including the current byte
	always_comb begin
		bits_n = bits_ok_q;
		text_n = text_ok_q;
		en_n   = en_ok_q;
		dis_n  = dis_ok_q;
		if (stored) begin
			bits_n = step(bits_ok_q, first, cnt_q < CW'(ucfp_pkg::LEN_MODE),
				byte_v == ucfp_pkg::lit_char(ucfp_pkg::LIT_BITS, pos));
			text_n = step(text_ok_q, first, cnt_q < CW'(ucfp_pkg::LEN_MODE),
				byte_v == ucfp_pkg::lit_char(ucfp_pkg::LIT_TEXT, pos));
			en_n   = step(en_ok_q, first, cnt_q < CW'(ucfp_pkg::LEN_EN),
				byte_v == ucfp_pkg::lit_char(ucfp_pkg::LIT_EN, pos));
			dis_n  = step(dis_ok_q, first, cnt_q < CW'(ucfp_pkg::LEN_DIS),
				byte_v == ucfp_pkg::lit_char(ucfp_pkg::LIT_DIS, pos));
		end
		dig_en_ok_n  = (cnt_q == CW'(ucfp_pkg::LEN_EN)) ? is_digit : dig_en_ok_q;
		dig_en_n     = (cnt_q == CW'(ucfp_pkg::LEN_EN)) ? byte_v[2:0] : dig_en_q;
		dig_dis_ok_n = (cnt_q == CW'(ucfp_pkg::LEN_DIS)) ? is_digit : dig_dis_ok_q;
		dig_dis_n    = (cnt_q == CW'(ucfp_pkg::LEN_DIS)) ? byte_v[2:0] : dig_dis_q;
		frame_hit    = (cnt_q == CW'(3)) && head_ok_q && crc_ok_q &&
			(byte_v == ucfp_pkg::FRAME_TAIL);
	end

	// classify the burst on its last byte
	always_comb begin
		push_rec.kind   = ucfp_pkg::CMD_NONE;
		push_rec.nibble = payload_q[3:0];
		push_rec.pin    = dig_en_n;
		priority if (frame_hit) begin
			push_rec.kind = ucfp_pkg::CMD_FRAME;
		end else if (bits_n && cnt_after >= CW'(ucfp_pkg::LEN_MODE)) begin
			push_rec.kind = ucfp_pkg::CMD_BITS;
		end else if (text_n && cnt_after >= CW'(ucfp_pkg::LEN_MODE)) begin
			push_rec.kind = ucfp_pkg::CMD_TEXT;
		end else if (en_n && cnt_after >= CW'(ucfp_pkg::LEN_EN)) begin
			if (cnt_after > CW'(ucfp_pkg::LEN_EN) && dig_en_ok_n)
				push_rec.kind = ucfp_pkg::CMD_ENABLE;
		end else if (dis_n && cnt_after >= CW'(ucfp_pkg::LEN_DIS)) begin
			push_rec.pin = dig_dis_n;
			if (cnt_after > CW'(ucfp_pkg::LEN_DIS) && dig_dis_ok_n)
				push_rec.kind = ucfp_pkg::CMD_DISABLE;
		end
		push_valid = rx.valid && rx.payload.burst_end;
		rx.ready   = push_ready;
	end

	// byte counter, saturating, cleared at burst end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (rx.payload.burst_end)
				cnt_q <= '0;
			else
				cnt_q <= cnt_after;
		end
	end

	// match state, rebuilt from the first byte of every burst
	always_ff @(posedge clk) begin
		if (accept) begin
			bits_ok_q    <= bits_n;
			text_ok_q    <= text_n;
			en_ok_q      <= en_n;
			dis_ok_q     <= dis_n;
			dig_en_ok_q  <= dig_en_ok_n;
			dig_en_q     <= dig_en_n;
			dig_dis_ok_q <= dig_dis_ok_n;
			dig_dis_q    <= dig_dis_n;
			if (first)
				head_ok_q <= (byte_v == ucfp_pkg::FRAME_HEAD);
			if (cnt_q == CW'(1))
				payload_q <= byte_v;
			if (cnt_q == CW'(2))
				crc_ok_q <= (ucfp_pkg::crc8(payload_q) == byte_v);
		end
	end

endmodule

[rtl/core/ucfp_queue.sv]
// two-entry queue of classified bursts between front and back
module ucfp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ucfp_pkg::burst_rec_t push_rec,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output ucfp_pkg::burst_rec_t pop_rec
);

	ucfp_pkg::burst_rec_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push, do_pop;

	// handshake
	always_comb begin
		push_ready = (fill_q != 2'd2);
		pop_valid  = (fill_q != 2'd0);
		pop_rec    = mem_q[rd_ptr_q];
		do_push    = push_valid && push_ready;
		do_pop     = pop_valid && pop_ready;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_rec;
	end

endmodule

[rtl/core/ucfp_back.sv]
// back end: keeps the report mode and builds the registered result item
module ucfp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  ucfp_pkg::burst_rec_t pop_rec,
	ucfp_stream_if.source        result
);

	logic                 out_valid_q;
	ucfp_pkg::res_item_t  out_q;
	ucfp_pkg::res_item_t  res_n;
	logic                 mode_q;
	logic [4:0]           pin_bit;
	logic                 take;

	// result of the record at the head of the queue
	always_comb begin
		pin_bit          = 5'd1 << pop_rec.pin;
		res_n.command    = pop_rec.kind;
		res_n.pin_mask   = '0;
		res_n.pin_levels = '0;
		res_n.bits_mode  = mode_q;
		unique case (pop_rec.kind)
			ucfp_pkg::CMD_FRAME: begin
				res_n.pin_mask   = {1'b0, ucfp_pkg::FRAME_PINS};
				res_n.pin_levels = {1'b0, pop_rec.nibble};
			end
			ucfp_pkg::CMD_BITS: res_n.bits_mode = 1'b1;
			ucfp_pkg::CMD_TEXT: res_n.bits_mode = 1'b0;
			ucfp_pkg::CMD_ENABLE: begin
				res_n.pin_mask   = pin_bit;
				res_n.pin_levels = pin_bit;
			end
			ucfp_pkg::CMD_DISABLE: res_n.pin_mask = pin_bit;
			default: res_n.command = ucfp_pkg::CMD_NONE;
		endcase
		pop_ready      = !out_valid_q || result.ready;
		take           = pop_valid && pop_ready;
		result.valid   = out_valid_q;
		result.payload = out_q;
	end

	// output valid and report mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mode_q      <= 1'b0;
		end else begin
			if (pop_ready)
				out_valid_q <= pop_valid;
			if (take)
				mode_q <= res_n.bits_mode;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take)
			out_q <= res_n;
	end

endmodule

[rtl/core/uart_command_frame_parser.sv]
// uart command frame parser: one result item per byte burst
// Throughput: one byte per cycle while the queue has room; the prefix match runs on each byte as it arrives.
// After its last byte is taken, the result of a burst is registered in the queue and then in the
// output register, where it waits while the result side stalls.
// Reset: arst_n clears the byte count, queue, output valid and report mode (text mode);
// no clearing pass, bytes are taken from the first cycle after reset.
`include "uart_command_frame_parser_macros.svh"

module uart_command_frame_parser #(
	parameter int BURST_BYTES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	ucfp_stream_if.sink   rx,
	ucfp_stream_if.source result
);

	logic                 push_valid, push_ready;
	logic                 pop_valid, pop_ready;
	ucfp_pkg::burst_rec_t push_rec, pop_rec;

	// byte intake and classification
	ucfp_front #(
		.BURST_BYTES(BURST_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_rec  (push_rec)
	);

	// decoupling queue
	ucfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_rec  (push_rec),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_rec   (pop_rec)
	);

	// command execution and result register
	ucfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_rec  (pop_rec),
		.result   (result)
	);

	// checks on result contents and on the queueing of each finished burst
	`UCFP_ASSERT_IMPLY(a_quiet_pins, clk, arst_n, result.valid && (result.payload.command == ucfp_pkg::CMD_NONE || result.payload.command == ucfp_pkg::CMD_BITS || result.payload.command == ucfp_pkg::CMD_TEXT), result.payload.pin_mask == 5'd0 && result.payload.pin_levels == 5'd0)
	`UCFP_ASSERT_IMPLY(a_enable_one_pin, clk, arst_n, result.valid && result.payload.command == ucfp_pkg::CMD_ENABLE, $onehot(result.payload.pin_mask) && result.payload.pin_levels == result.payload.pin_mask)
	`UCFP_ASSERT_IMPLY(a_bits_mode_set, clk, arst_n, result.valid && result.payload.command == ucfp_pkg::CMD_BITS, result.payload.bits_mode)
	`UCFP_ASSERT_NEXT(a_burst_queued, clk, arst_n, rx.valid && rx.ready && rx.payload.burst_end, pop_valid || result.valid)

endmodule

[tb/sv/ucfp_result_checker.sv]
// result checker for the uart command frame parser: predicts each burst outcome and compares
module ucfp_result_checker import ucfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rx_valid,
	input  logic      rx_ready,
	input  rx_item_t  rx_item,
	input  logic      res_valid,
	input  logic      res_ready,
	input  res_item_t res_item,
	output int        mismatches,
	output int        outstanding
);

	localparam int BURST_DEPTH = 16;

	// predicted parser state
	logic [7:0] burst_mem [BURST_DEPTH];
	int         burst_len;
	logic       bits_mode_q;
	res_item_t  expected_q [$];

	// crc-8, poly 0x07, zero start, one byte
	function automatic logic [7:0] crc_of(input logic [7:0] b);
		logic [7:0] c;
		c = b;
		repeat (8) begin
			if (c[7]) begin
				c = (c << 1) ^ 8'h07;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	// stored bytes start with the first n characters of a command text
	function automatic logic prefix_hit(input logic [127:0] lit, input int n);
		if (burst_len < n) begin
			return 1'b0;
		end
		for (int k = 0; k < n; k++) begin
			if (burst_mem[k] != lit[127 - 8 * k -: 8]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// pin number from the byte at pos, -1 when absent or out of range
	function automatic int digit_at(input int pos);
		if (pos >= burst_len || pos >= BURST_DEPTH) begin
			return -1;
		end
		if (burst_mem[pos] < DIGIT_LO || burst_mem[pos] > DIGIT_HI) begin
			return -1;
		end
		return int'(burst_mem[pos] - DIGIT_LO);
	endfunction

	// store one byte and, at burst end, work out the result item
	task automatic take_byte(input rx_item_t it);
		res_item_t r;
		int        pin;
		if (burst_len < BURST_DEPTH) begin
			burst_mem[burst_len] = it.data_byte;
			burst_len++;
		end
		if (!it.burst_end) begin
			return;
		end
		r = '0;
		r.command = CMD_NONE;
		if (burst_len == 4 && burst_mem[0] == FRAME_HEAD && burst_mem[3] == FRAME_TAIL &&
			crc_of(burst_mem[1]) == burst_mem[2]) begin
			r.command = CMD_FRAME;
			r.pin_mask = {1'b0, FRAME_PINS};
			r.pin_levels = {1'b0, burst_mem[1][3:0]};
		end else if (prefix_hit(LIT_BITS, LEN_MODE)) begin
			r.command = CMD_BITS;
			bits_mode_q = 1'b1;
		end else if (prefix_hit(LIT_TEXT, LEN_MODE)) begin
			r.command = CMD_TEXT;
			bits_mode_q = 1'b0;
		end else if (prefix_hit(LIT_EN, LEN_EN)) begin
			pin = digit_at(LEN_EN);
			if (pin >= 0) begin
				r.command = CMD_ENABLE;
				r.pin_mask = 5'd1 << pin;
				r.pin_levels = r.pin_mask;
			end
		end else if (prefix_hit(LIT_DIS, LEN_DIS)) begin
			pin = digit_at(LEN_DIS);
			if (pin >= 0) begin
				r.command = CMD_DISABLE;
				r.pin_mask = 5'd1 << pin;
			end
		end
		r.bits_mode = bits_mode_q;
		burst_len = 0;
		expected_q.push_back(r);
	endtask

	// count a bad result, print the first few
	task automatic report_bad(input res_item_t want, input res_item_t got, input logic orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan) begin
				$display("checker: result cmd=%0d mask=%b levels=%b mode=%b with no burst pending",
					got.command, got.pin_mask, got.pin_levels, got.bits_mode);
			end else begin
				$display("checker: expected cmd=%0d mask=%b levels=%b mode=%b, got cmd=%0d mask=%b levels=%b mode=%b",
					want.command, want.pin_mask, want.pin_levels, want.bits_mode,
					got.command, got.pin_mask, got.pin_levels, got.bits_mode);
			end
		end
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// compare accepted results first, then predict from accepted bytes
	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			expected_q.delete();
			burst_len = 0;
			bits_mode_q = 1'b0;
			for (int k = 0; k < BURST_DEPTH; k++) begin
				burst_mem[k] = 8'h00;
			end
			outstanding = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					report_bad(res_item, res_item, 1'b1);
				end else begin
					want = expected_q.pop_front();
					if (res_item.command !== want.command || res_item.pin_mask !== want.pin_mask ||
						res_item.pin_levels !== want.pin_levels ||
						res_item.bits_mode !== want.bits_mode) begin
						report_bad(want, res_item, 1'b0);
					end
				end
			end
			if (rx_valid && rx_ready) begin
				take_byte(rx_item);
			end
			outstanding = expected_q.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// top of the uart command frame parser testbench: clock, reset, byte bursts and verdict
module tb;
	import ucfp_pkg::*;

	logic clk;
	logic arst_n;
	logic hold_req;
	int   run_left;
	int   mismatch_cnt;
	int   pending_cnt;
	logic [7:0] burst_q [$];

	ucfp_stream_if #(.payload_t(rx_item_t))  rx_ch ();
	ucfp_stream_if #(.payload_t(res_item_t)) res_ch ();

	uart_command_frame_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.result (res_ch)
	);

	ucfp_result_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_ch.valid),
		.rx_ready    (rx_ch.ready),
		.rx_item     (rx_ch.payload),
		.res_valid   (res_ch.valid),
		.res_ready   (res_ch.ready),
		.res_item    (res_ch.payload),
		.mismatches  (mismatch_cnt),
		.outstanding (pending_cnt)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hard stop
	initial begin
		#4000000;
		$display("uart_command_frame_parser regression: fail");
		$finish;
	end

	// offer one byte, idling between runs of random length
	task automatic send_item(input logic [7:0] b, input logic last);
		int       gap;
		rx_item_t it;
		if (run_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			run_left = $urandom_range(1, 32);
		end
		it.data_byte = b;
		it.burst_end = last;
		rx_ch.valid <= 1'b1;
		rx_ch.payload <= it;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		run_left--;
	endtask

	// send the queued bytes, marking the last one as burst end
	task automatic send_burst();
		for (int k = 0; k < burst_q.size(); k++) begin
			send_item(burst_q[k], k == burst_q.size() - 1);
		end
	endtask

	task automatic add_text(input logic [127:0] lit, input int n);
		for (int k = 0; k < n; k++) begin
			burst_q.push_back(lit[127 - 8 * k -: 8]);
		end
	endtask

	task automatic add_command(input int which);
		case (which)
			0: add_text(LIT_BITS, LEN_MODE);
			1: add_text(LIT_TEXT, LEN_MODE);
			2: add_text(LIT_EN, LEN_EN);
			default: add_text(LIT_DIS, LEN_DIS);
		endcase
	endtask

	task automatic add_frame(input logic [7:0] payload);
		burst_q.push_back(FRAME_HEAD);
		burst_q.push_back(payload);
		burst_q.push_back(crc8(payload));
		burst_q.push_back(FRAME_TAIL);
	endtask

	task automatic add_noise(input int n);
		repeat (n) burst_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// pin digit after an enable or disable text: mostly good, some bad, some missing
	task automatic add_pin_digit();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			burst_q.push_back(DIGIT_LO + 8'($urandom_range(0, 4)));
			add_noise($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
		end else if (pick < 17) begin
			add_noise(1);
		end
	endtask

	// one random burst, mostly well formed
	task automatic build_random_burst();
		int kind;
		int which;
		int pos;
		burst_q.delete();
		kind = $urandom_range(0, 11);
		which = $urandom_range(0, 3);
		case (kind)
			0, 1: add_frame(8'($urandom_range(0, 255)));
			2: begin
				add_frame(8'($urandom_range(0, 255)));
				case ($urandom_range(0, 2))
					0: begin
						pos = $urandom_range(0, 3);
						burst_q[pos] = burst_q[pos] ^ 8'($urandom_range(1, 255));
					end
					1: add_noise(1);
					default: void'(burst_q.pop_back());
				endcase
			end
			3, 4: begin
				add_command(kind - 3);
				add_noise($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 6));
			end
			5, 6, 7, 8: begin
				add_command(kind < 7 ? 2 : 3);
				add_pin_digit();
			end
			9: begin
				// near miss: one altered character, or a cut-off command
				add_command(which);
				if ($urandom_range(0, 1) == 0) begin
					pos = $urandom_range(0, burst_q.size() - 1);
					burst_q[pos] = burst_q[pos] ^ 8'($urandom_range(1, 255));
					if (which >= 2) add_pin_digit();
				end else begin
					repeat ($urandom_range(1, burst_q.size() - 1)) void'(burst_q.pop_back());
				end
			end
			10: add_noise($urandom_range(1, 24));
			default: begin
				// overlong burst past the stored bytes
				add_command(which);
				if (which >= 2) burst_q.push_back(DIGIT_LO + 8'($urandom_range(0, 4)));
				add_noise($urandom_range(4, 10));
			end
		endcase
	endtask

	// result side: stall patterns that change every stretch, plus long hold-offs on request
	initial begin
		int style;
		int left;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				@(posedge clk);
				res_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end
			style = $urandom_range(0, 4);
			left = $urandom_range(16, 96);
			while (left > 0) begin
				@(posedge clk);
				case (style)
					0, 1: res_ch.ready <= 1'b1;
					2: res_ch.ready <= ($urandom_range(0, 3) != 0);
					3: res_ch.ready <= ($urandom_range(0, 3) == 0);
					default: res_ch.ready <= left[0];
				endcase
				left--;
			end
		end
	end

	// reset, directed bursts, random bursts, drain and verdict
	initial begin
		int sent;
		int guard;
		logic hold1_done;
		logic hold2_done;
		rx_ch.valid <= 1'b0;
		rx_ch.payload <= '0;
		arst_n <= 1'b0;
		hold_req = 1'b0;
		run_left = 0;
		sent = 0;
		guard = 0;
		hold1_done = 1'b0;
		hold2_done = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// good frame, all payload bits set
		burst_q.delete();
		add_frame(8'hFF);
		send_burst();
		// frame with a bad crc, zero payload
		burst_q.delete();
		add_frame(8'h00);
		burst_q[2] = burst_q[2] ^ 8'h01;
		send_burst();
		// single zero byte burst
		burst_q.delete();
		burst_q.push_back(8'h00);
		send_burst();
		// disable with all sixteen bytes used
		burst_q.delete();
		add_command(3);
		burst_q.push_back(DIGIT_LO);
		send_burst();

		// random bursts with two long result-side hold-offs on the way
		while (sent < 750) begin
			if (!hold1_done && sent > 200) begin
				hold_req = 1'b1;
				hold1_done = 1'b1;
			end
			if (!hold2_done && sent > 550) begin
				hold_req = 1'b1;
				hold2_done = 1'b1;
			end
			build_random_burst();
			send_burst();
			sent += burst_q.size();
		end
		rx_ch.valid <= 1'b0;
		// let the checker record the last burst before looking at its count
		@(posedge clk);

		// drain remaining results
		while (pending_cnt != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0 && pending_cnt == 0) begin
			$display("uart_command_frame_parser regression: pass");
		end else begin
			$display("uart_command_frame_parser regression: fail");
		end
		$finish;
	end

endmodule
